>>> hw/rtl/ipds_pkg.sv
`timescale 1ns / 1ps

package ipds_pkg;

   // Field widths
   localparam int ModeWidth      = 2;
   localparam int TimeWidth      = 32;
   localparam int VolWidth       = 16;
   localparam int PlantWidth     = 8;
   localparam int FlowWidth      = 20;
   localparam int TickWidth      = 16;
   localparam int HoursWidth     = 8;
   localparam int ResWidth       = 32;
   localparam int DoseWidth      = VolWidth + PlantWidth;      // 24
   localparam int HourSecWidth   = 12;
   localparam int NumWidth       = DoseWidth + HourSecWidth;   // 36
   localparam int MsScaleWidth   = 10;
   localparam int RunMsWidth     = TimeWidth + MsScaleWidth;   // 42
   localparam int IntervalWidth  = HoursWidth + HourSecWidth;  // 20

   // Divider runs one quotient bit per cycle
   localparam int DivSteps    = NumWidth;
   localparam int DivCntWidth = $clog2(DivSteps);

   // Constants
   localparam logic [HourSecWidth-1:0] SecPerHour = 12'd3600;
   localparam logic [MsScaleWidth-1:0] MsPerSec   = 10'd1000;

   // Register reset values
   localparam logic [HoursWidth-1:0] IntervalReset = 8'd0;
   localparam logic [VolWidth-1:0]   VolumeReset   = 16'd0;
   localparam logic [PlantWidth-1:0] PlantReset    = 8'd2;
   localparam logic [FlowWidth-1:0]  FlowReset     = 20'd12300;
   localparam logic [TickWidth-1:0]  TickReset     = 16'd500;

   // Register word indexes (byte address / 4)
   localparam int CsrAddrWidth = 5;
   typedef enum logic [2:0] {
      REG_INTERVAL = 3'd0,
      REG_VOLUME   = 3'd1,
      REG_PLANTS   = 3'd2,
      REG_FLOW     = 3'd3,
      REG_TICK     = 3'd4
   } reg_index_type;

   // Request kinds
   typedef enum logic [ModeWidth-1:0] {
      MODE_TICK   = 2'd0,
      MODE_MANUAL = 2'd1,
      MODE_STOP   = 2'd2,
      MODE_SETRES = 2'd3
   } mode_type;

   // Stream payload widths
   localparam int ReqDataWidth = 80;
   localparam int RspDataWidth = 136;

   typedef struct packed {
      logic [HoursWidth-1:0] interval_hours;
      logic [VolWidth-1:0]   volume_per_plant_ml;
      logic [PlantWidth-1:0] plant_count;
      logic [FlowWidth-1:0]  pump_flow_ml_per_h;
      logic [TickWidth-1:0]  tick_period_ms;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic eval;
      logic dose;
      logic scale;
      logic div_step;
      logic msec;
      logic commit;
      logic load_out;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic start_go;
      logic out_free;
   } ctrl_sts_type;

endpackage

>>> hw/rtl/ipds_csr.sv
`timescale 1ns / 1ps

module ipds_csr import ipds_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready,
   output cfg_type                 cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign idx        = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_INTERVAL: cfg_in.interval_hours      = csr_pwdata[HoursWidth-1:0];
            REG_VOLUME:   cfg_in.volume_per_plant_ml = csr_pwdata[VolWidth-1:0];
            REG_PLANTS:   cfg_in.plant_count         = csr_pwdata[PlantWidth-1:0];
            REG_FLOW:     cfg_in.pump_flow_ml_per_h  = csr_pwdata[FlowWidth-1:0];
            REG_TICK:     cfg_in.tick_period_ms      = csr_pwdata[TickWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_hours      <= IntervalReset;
         cfg_ff.volume_per_plant_ml <= VolumeReset;
         cfg_ff.plant_count         <= PlantReset;
         cfg_ff.pump_flow_ml_per_h  <= FlowReset;
         cfg_ff.tick_period_ms      <= TickReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (idx)
         REG_INTERVAL: csr_prdata = {{(32-HoursWidth){1'b0}}, cfg_ff.interval_hours};
         REG_VOLUME:   csr_prdata = {{(32-VolWidth){1'b0}}, cfg_ff.volume_per_plant_ml};
         REG_PLANTS:   csr_prdata = {{(32-PlantWidth){1'b0}}, cfg_ff.plant_count};
         REG_FLOW:     csr_prdata = {{(32-FlowWidth){1'b0}}, cfg_ff.pump_flow_ml_per_h};
         REG_TICK:     csr_prdata = {{(32-TickWidth){1'b0}}, cfg_ff.tick_period_ms};
         default:      csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/ipds_ctrl.sv
`timescale 1ns / 1ps

module ipds_ctrl import ipds_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_EVAL   = 8'b0000_0010,
      ST_DOSE   = 8'b0000_0100,
      ST_SCALE  = 8'b0000_1000,
      ST_DIVIDE = 8'b0001_0000,
      ST_MSEC   = 8'b0010_0000,
      ST_COMMIT = 8'b0100_0000,
      ST_OUT    = 8'b1000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic [DivCntWidth-1:0] cnt_ff, cnt_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.start_go ? ST_DOSE : ST_OUT;
         end
         ST_DOSE: begin
            cmd.dose = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            cnt_in    = '0;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DivCntWidth'(DivSteps - 1)) begin
               state_in = ST_MSEC;
            end
         end
         ST_MSEC: begin
            cmd.msec = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> hw/rtl/ipds_dp.sv
`timescale 1ns / 1ps

module ipds_dp import ipds_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  ctrl_cmd_type            cmd,
   output ctrl_sts_type            sts,
   input  logic [ModeWidth-1:0]    req_mode,
   input  logic [TimeWidth-1:0]    req_now,
   input  logic [VolWidth-1:0]     req_svol,
   input  logic [ResWidth-1:0]     req_load,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata
);

   // Captured request
   mode_type             mode_ff;
   logic [TimeWidth-1:0] now_ff;
   logic [VolWidth-1:0]  svol_ff;
   logic [ResWidth-1:0]  load_ff;

   // Scheduler state
   logic [RunMsWidth-1:0] run_ms_ff, run_ms_in;
   logic                  pump_ff, pump_in;
   logic [TimeWidth-1:0]  last_ff, last_in;
   logic [TimeWidth-1:0]  next_ff, next_in;
   logic [ResWidth-1:0]   res_ff, res_in;

   // Per-request flags and run arithmetic
   logic                   started_ff, started_in;
   logic                   save_ff, save_in;
   logic [TimeWidth-1:0]   secs_ff, secs_in;
   logic [VolWidth-1:0]    vol_ff;
   logic [DoseWidth-1:0]   dose_ff;
   logic [NumWidth-1:0]    quo_ff;
   logic [FlowWidth-1:0]   rem_ff;
   logic [RunMsWidth-1:0]  new_ms_ff;
   logic [TimeWidth-1:0]   new_next_ff;

   // Output register
   logic                    out_valid_ff;
   logic [RspDataWidth-1:0] out_data_ff;

   // Eval helpers
   logic [RunMsWidth-1:0] tick_ext;
   logic [RunMsWidth-1:0] dec_ms;
   logic                  auto_due;
   logic                  attempt;
   logic [VolWidth-1:0]   vol_sel;
   logic                  blocked;

   // Divider step
   logic [FlowWidth:0] trial;
   logic [FlowWidth:0] diff;
   logic               ge;

   // Saturation
   logic [TimeWidth-1:0] sat_secs;

   // Reservoir after dose
   logic [ResWidth-1:0] dose_ext;

   // Interval in seconds
   logic [IntervalWidth-1:0] interval_s;

   assign tick_ext = {{(RunMsWidth-TickWidth){1'b0}}, cfg.tick_period_ms};
   assign dec_ms   = (run_ms_ff > tick_ext) ? (run_ms_ff - tick_ext) : '0;
   assign auto_due = (cfg.interval_hours != '0) && (now_ff >= next_ff);
   assign attempt  = ((mode_ff == MODE_TICK) && (dec_ms == '0) && auto_due) ||
                     (mode_ff == MODE_MANUAL);
   assign vol_sel  = (mode_ff == MODE_MANUAL) ? svol_ff : cfg.volume_per_plant_ml;
   assign blocked  = (vol_sel == '0) || (cfg.pump_flow_ml_per_h == '0);

   assign sts.start_go = attempt & ~blocked;
   assign sts.out_free = ~out_valid_ff | rsp_tready;

   assign trial = {rem_ff, quo_ff[NumWidth-1]};
   assign diff  = trial - {1'b0, cfg.pump_flow_ml_per_h};
   assign ge    = (trial >= {1'b0, cfg.pump_flow_ml_per_h});

   assign sat_secs = (quo_ff[NumWidth-1:TimeWidth] != '0) ? '1 : quo_ff[TimeWidth-1:0];
   assign dose_ext = {{(ResWidth-DoseWidth){1'b0}}, dose_ff};

   // hours * 3600 needs the full 20 bits
   assign interval_s = IntervalWidth'(cfg.interval_hours) * IntervalWidth'(SecPerHour);

   // Capture request payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= mode_type'(req_mode);
         now_ff  <= req_now;
         svol_ff <= req_svol;
         load_ff <= req_load;
      end
   end

   // State updates for eval and commit
   always_comb begin
      run_ms_in  = run_ms_ff;
      pump_in    = pump_ff;
      last_in    = last_ff;
      next_in    = next_ff;
      res_in     = res_ff;
      started_in = started_ff;
      save_in    = save_ff;
      secs_in    = secs_ff;
      if (cmd.eval) begin
         started_in = 1'b0;
         save_in    = 1'b0;
         secs_in    = '0;
         case (mode_ff)
            MODE_TICK: begin
               run_ms_in = dec_ms;
               pump_in   = (dec_ms != '0);
               save_in   = (dec_ms == '0) && auto_due;
            end
            MODE_STOP: begin
               run_ms_in = '0;
               pump_in   = 1'b0;
            end
            MODE_SETRES: res_in = load_ff;
            default: ;
         endcase
         // blocked start clears the timer
         if (attempt && blocked) begin
            run_ms_in = '0;
         end
      end
      if (cmd.commit) begin
         started_in = 1'b1;
         save_in    = 1'b1;
         last_in    = now_ff;
         next_in    = new_next_ff;
         res_in     = (res_ff > dose_ext) ? (res_ff - dose_ext) : '0;
         run_ms_in  = new_ms_ff;
      end
      if (cmd.msec) begin
         secs_in = sat_secs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ms_ff  <= '0;
         pump_ff    <= 1'b0;
         last_ff    <= '0;
         next_ff    <= '0;
         res_ff     <= '0;
         started_ff <= 1'b0;
         save_ff    <= 1'b0;
         secs_ff    <= '0;
      end else begin
         run_ms_ff  <= run_ms_in;
         pump_ff    <= pump_in;
         last_ff    <= last_in;
         next_ff    <= next_in;
         res_ff     <= res_in;
         started_ff <= started_in;
         save_ff    <= save_in;
         secs_ff    <= secs_in;
      end
   end

   // Run duration arithmetic: dose, numerator, restoring divide, ms scale, next start time
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         vol_ff <= vol_sel;
      end
      if (cmd.dose) begin
         dose_ff <= DoseWidth'(vol_ff) * DoseWidth'(cfg.plant_count);
      end
      if (cmd.scale) begin
         quo_ff <= NumWidth'(dose_ff) * NumWidth'(SecPerHour);
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         quo_ff <= {quo_ff[NumWidth-2:0], ge};
         rem_ff <= ge ? diff[FlowWidth-1:0] : trial[FlowWidth-1:0];
      end
      if (cmd.msec) begin
         new_ms_ff   <= RunMsWidth'(sat_secs) * RunMsWidth'(MsPerSec);
         new_next_ff <= now_ff + {{(TimeWidth-IntervalWidth){1'b0}}, interval_s};
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_data_ff <= {5'd0, save_ff, last_ff, next_ff, res_ff, secs_ff,
                         started_ff, pump_ff};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

>>> hw/rtl/interval_dosing_pump_scheduler_top.sv
`timescale 1ns / 1ps

// Channel   | ports                         | carries
// ----------+-------------------------------+--------------------------------------
// request   | req_tvalid/tready/tdata/tuser | mode, time, manual volume, reservoir
// response  | rsp_tvalid/tready/tdata       | pump state, run info, times, save flag
// config    | csr_psel/penable/pwrite...    | five scheduler registers, APB style
//
// One request at a time. A request that begins no run goes from accept through
// evaluate to output. One that starts a run also passes dose, scale, divide,
// msec and commit; the run length goes through a restoring divider that yields
// one quotient bit a cycle. Reset is synchronous and clears the run timer, pump,
// start times and reservoir count. A response held by rsp_tready stays in the
// output register while the next request is accepted and worked on.

module interval_dosing_pump_scheduler_top import ipds_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [31:0] now_seconds, [47:32] start_volume_ml, [79:48] reservoir_load_ml
   input  logic [ReqDataWidth-1:0] req_tdata,
   // [1:0] mode
   input  logic [ModeWidth-1:0]    req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [0] pump_on, [1] run_started, [33:2] run_seconds, [65:34] reservoir_left_ml,
   // [97:66] next_start_seconds, [129:98] last_start_seconds, [130] save_request
   output logic [RspDataWidth-1:0] rsp_tdata,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   cfg_type      cfg;
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   ipds_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ipds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ipds_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .sts        (sts),
      .req_mode   (req_tuser),
      .req_now    (req_tdata[31:0]),
      .req_svol   (req_tdata[47:32]),
      .req_load   (req_tdata[79:48]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
